### hw/rtl/atsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsc_pkg
// Shared constants, register indexes and the controller/datapath command and
// status types for the asymmetric tube soft clipper.
// ----------------------------------------------------------------------------
package atsc_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int AMT_W   = 15;
  localparam int GAIN_W  = 16;
  localparam int ASYM_W  = 17;
  localparam int RATE_W  = 14;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POST_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASYMMETRY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd4;

  localparam logic [AMT_W-1:0]  RST_AMOUNT    = 15'd0;
  localparam logic [GAIN_W-1:0] RST_PRE_GAIN  = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_POST_GAIN = 16'd4096;
  localparam logic [ASYM_W-1:0] RST_ASYMMETRY = 17'd32768;
  localparam logic [RATE_W-1:0] RST_RATE      = 14'd655;

  // Deadbands equivalent to 0.01 in each register's format.
  localparam logic [ASYM_W-1:0] BAND_AMOUNT = 17'd3;
  localparam logic [ASYM_W-1:0] BAND_GAIN   = 17'd41;
  localparam logic [ASYM_W-1:0] BAND_ASYM   = 17'd656;

  // Multiplier operand selections.
  localparam logic [3:0] MUL_SM_AMT  = 4'd0;
  localparam logic [3:0] MUL_SM_PRE  = 4'd1;
  localparam logic [3:0] MUL_SM_POST = 4'd2;
  localparam logic [3:0] MUL_SM_ASYM = 4'd3;
  localparam logic [3:0] MUL_DRIVE   = 4'd4;
  localparam logic [3:0] MUL_ARG     = 4'd5;
  localparam logic [3:0] MUL_IDX     = 4'd6;
  localparam logic [3:0] MUL_INTERP  = 4'd7;
  localparam logic [3:0] MUL_POST    = 4'd8;
  localparam logic [3:0] MUL_MIX     = 4'd9;
  localparam logic [3:0] MUL_RECIP   = 4'd10;

  // Smoothed parameter selections.
  localparam logic [1:0] PAR_AMOUNT = 2'd0;
  localparam logic [1:0] PAR_PRE    = 2'd1;
  localparam logic [1:0] PAR_POST   = 2'd2;
  localparam logic [1:0] PAR_ASYM   = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       sm_upd;
    logic [1:0] sm_par;
    logic       lat_x;
    logic       lat_u;
    logic       lat_idx;
    logic       rom_hi;
    logic       lat_lo;
    logic       lat_diff;
    logic       lat_y;
    logic       lat_w;
    logic       lat_d;
    logic       lat_t;
    logic       load_out;
    logic       bypass;
  } dp_cmd_t;

  typedef struct packed {
    logic amount_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/atsc_exp_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsc_exp_rom
// Table of exp(-16k/D) in the sample format, with a registered read port.
// ----------------------------------------------------------------------------
module atsc_exp_rom #(
  parameter int SAMPLE_WIDTH    = atsc_pkg::SAMPLE_WIDTH,
  parameter int EXP_TABLE_DEPTH = atsc_pkg::EXP_TABLE_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic [$clog2(EXP_TABLE_DEPTH+1)-1:0]  addr,
  output logic      [SAMPLE_WIDTH-3:0]               q
);

  localparam int F  = SAMPLE_WIDTH - 3;
  localparam int EW = F + 1;
  localparam int RS = 30 - F;

  typedef logic [EW-1:0] rom_t [EXP_TABLE_DEPTH+1];

  // Series for exp(-k/D) in Q.30, then raised to the 16th power by squaring.
  function automatic rom_t build_rom();
    rom_t              rom;
    longint unsigned   a;
    longint unsigned   term;
    longint            sum;
    longint unsigned   s;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      a    = (longint'(k) << 30) / EXP_TABLE_DEPTH;
      term = 64'd1 << 30;
      sum  = 64'sd1 <<< 30;
      for (int N = 1; N <= 20; N++) begin
        term = ((term * a) >> 30) / N;
        if (N % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      s = longint'(sum);
      for (int j = 0; j < 4; j++) s = (s * s + (64'd1 << 29)) >> 30;
      rom[k] = EW'((s + (64'd1 << (RS - 1))) >> RS);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [EW-1:0] q_r;

  always_ff @(posedge clk) begin
    q_r <= ROM[addr];
  end

  assign q = q_r;

endmodule
`default_nettype wire

### hw/rtl/atsc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsc_ctrl
// Sequencer that walks one sample through the shared multiplier datapath and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module atsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_smooth_tick,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output atsc_pkg::dp_cmd_t       cmd,
  input  wire atsc_pkg::dp_stat_t stat
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SM0  = 5'd1;
  localparam logic [4:0] S_SM1  = 5'd2;
  localparam logic [4:0] S_SM2  = 5'd3;
  localparam logic [4:0] S_SM3  = 5'd4;
  localparam logic [4:0] S_SM4  = 5'd5;
  localparam logic [4:0] S_DRV  = 5'd6;
  localparam logic [4:0] S_XL   = 5'd7;
  localparam logic [4:0] S_ARG  = 5'd8;
  localparam logic [4:0] S_UL   = 5'd9;
  localparam logic [4:0] S_IDX  = 5'd10;
  localparam logic [4:0] S_IL   = 5'd11;
  localparam logic [4:0] S_RLO  = 5'd12;
  localparam logic [4:0] S_RHI  = 5'd13;
  localparam logic [4:0] S_DIF  = 5'd14;
  localparam logic [4:0] S_INT  = 5'd15;
  localparam logic [4:0] S_Y    = 5'd16;
  localparam logic [4:0] S_PG   = 5'd17;
  localparam logic [4:0] S_W    = 5'd18;
  localparam logic [4:0] S_D    = 5'd19;
  localparam logic [4:0] S_MIX  = 5'd20;
  localparam logic [4:0] S_T    = 5'd21;
  localparam logic [4:0] S_RCP  = 5'd22;
  localparam logic [4:0] S_OUT  = 5'd23;
  localparam logic [4:0] S_BYP  = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_smooth_tick ? S_SM0 : S_DRV;
        end
      end
      S_SM0: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_SM_AMT;
        state_nxt  = S_SM1;
      end
      S_SM1: begin
        cmd.sm_upd = 1'b1; cmd.sm_par = atsc_pkg::PAR_AMOUNT;
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_SM_PRE;
        state_nxt  = S_SM2;
      end
      S_SM2: begin
        cmd.sm_upd = 1'b1; cmd.sm_par = atsc_pkg::PAR_PRE;
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_SM_POST;
        state_nxt  = S_SM3;
      end
      S_SM3: begin
        cmd.sm_upd = 1'b1; cmd.sm_par = atsc_pkg::PAR_POST;
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_SM_ASYM;
        state_nxt  = S_SM4;
      end
      S_SM4: begin
        cmd.sm_upd = 1'b1; cmd.sm_par = atsc_pkg::PAR_ASYM;
        state_nxt  = S_DRV;
      end
      S_DRV: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_DRIVE;
        state_nxt  = stat.amount_zero ? S_BYP : S_XL;
      end
      S_XL:  begin cmd.lat_x = 1'b1; state_nxt = S_ARG; end
      S_ARG: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_ARG;
        state_nxt  = S_UL;
      end
      S_UL:  begin cmd.lat_u = 1'b1; state_nxt = S_IDX; end
      S_IDX: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_IDX;
        state_nxt  = S_IL;
      end
      S_IL:  begin cmd.lat_idx = 1'b1; state_nxt = S_RLO; end
      S_RLO: begin state_nxt = S_RHI; end
      S_RHI: begin cmd.lat_lo = 1'b1; cmd.rom_hi = 1'b1; state_nxt = S_DIF; end
      S_DIF: begin cmd.lat_diff = 1'b1; state_nxt = S_INT; end
      S_INT: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_INTERP;
        state_nxt  = S_Y;
      end
      S_Y:   begin cmd.lat_y = 1'b1; state_nxt = S_PG; end
      S_PG:  begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_POST;
        state_nxt  = S_W;
      end
      S_W:   begin cmd.lat_w = 1'b1; state_nxt = S_D; end
      S_D:   begin cmd.lat_d = 1'b1; state_nxt = S_MIX; end
      S_MIX: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_MIX;
        state_nxt  = S_T;
      end
      S_T:   begin cmd.lat_t = 1'b1; state_nxt = S_RCP; end
      S_RCP: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = atsc_pkg::MUL_RECIP;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BYP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.bypass   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/atsc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsc_dp
// Datapath: configuration and smoothed parameter registers, one shared
// multiplier, the exp table and the result register.
// ----------------------------------------------------------------------------
module atsc_dp #(
  parameter int SAMPLE_WIDTH    = atsc_pkg::SAMPLE_WIDTH,
  parameter int EXP_TABLE_DEPTH = atsc_pkg::EXP_TABLE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [atsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [atsc_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  input  wire logic                             in_snap_params,
  input  wire atsc_pkg::dp_cmd_t                cmd,
  output atsc_pkg::dp_stat_t                    stat,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out,
  output logic                                  out_bypassed
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = SW - 3;
  localparam int OPW   = SW + 8;
  localparam int PW    = 2 * OPW;
  localparam int XW    = SW + 3;
  localparam int CFW   = 19;
  localparam int UW    = SW + 6;
  localparam int SPAN  = F + 4;
  localparam int AW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EW    = F + 1;
  localparam int WMW   = SW + 2;
  localparam int WW    = SW + 3;
  localparam int DMW   = SW + 2;
  localparam int TW    = SW + 7;
  localparam int QS    = TW + 5;
  localparam int QW    = SW + 3;
  localparam int RW    = SW + 4;
  localparam int AMT_W  = atsc_pkg::AMT_W;
  localparam int GAIN_W = atsc_pkg::GAIN_W;
  localparam int ASYM_W = atsc_pkg::ASYM_W;
  localparam int RATE_W = atsc_pkg::RATE_W;
  localparam longint unsigned RECIP = ((64'd1 << QS) + 64'd24) / 64'd25;

  // Configuration targets.
  logic [AMT_W-1:0]  tgt_amount_r;
  logic [GAIN_W-1:0] tgt_pre_r, tgt_post_r;
  logic [ASYM_W-1:0] tgt_asym_r;
  logic [RATE_W-1:0] rate_r;

  // Current smoothed parameters.
  logic [AMT_W-1:0]  cur_amount_r, cur_amount_nxt;
  logic [GAIN_W-1:0] cur_pre_r, cur_pre_nxt, cur_post_r, cur_post_nxt;
  logic [ASYM_W-1:0] cur_asym_r, cur_asym_nxt;

  // Per-sample working registers.
  logic signed [SW-1:0] sample_r;
  logic [PW-1:0]        prod_r;
  logic [XW-1:0]        x_mag_r;
  logic                 x_pos_r;
  logic [UW-1:0]        u_r;
  logic [AW-1:0]        idx_r;
  logic [SPAN-1:0]      fr_r;
  logic [EW-1:0]        lo_r, diff_r;
  logic                 down_r;
  logic [EW-1:0]        y_mag_r;
  logic                 y_neg_r;
  logic signed [WW-1:0] w_r;
  logic [DMW-1:0]       d_mag_r;
  logic                 d_neg_r;
  logic [TW-1:0]        t_r;
  logic signed [SW-1:0] out_sample_r;
  logic                 out_bypassed_r;

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_amount_r <= atsc_pkg::RST_AMOUNT;
      tgt_pre_r    <= atsc_pkg::RST_PRE_GAIN;
      tgt_post_r   <= atsc_pkg::RST_POST_GAIN;
      tgt_asym_r   <= atsc_pkg::RST_ASYMMETRY;
      rate_r       <= atsc_pkg::RST_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atsc_pkg::REG_AMOUNT:    tgt_amount_r <= cfg_data[AMT_W-1:0];
        atsc_pkg::REG_PRE_GAIN:  tgt_pre_r    <= cfg_data[GAIN_W-1:0];
        atsc_pkg::REG_POST_GAIN: tgt_post_r   <= cfg_data[GAIN_W-1:0];
        atsc_pkg::REG_ASYMMETRY: tgt_asym_r   <= cfg_data[ASYM_W-1:0];
        atsc_pkg::REG_RATE:      rate_r       <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- smoothing ----------------
  logic [ASYM_W-1:0] damt, dasym;
  logic [16:0]       rate5, kgain;
  logic [ASYM_W-1:0] sm_cur, sm_tgt, sm_band, sm_diff, sm_new;
  logic [32:0]       sm_sum;
  logic [16:0]       sm_step;
  logic              sm_up;
  logic [ASYM_W:0]   sm_add, sm_sub;

  assign damt  = (cur_amount_r < tgt_amount_r)
               ? ASYM_W'(tgt_amount_r - cur_amount_r)
               : ASYM_W'(cur_amount_r - tgt_amount_r);
  assign dasym = (cur_asym_r < tgt_asym_r) ? (tgt_asym_r - cur_asym_r)
                                           : (cur_asym_r - tgt_asym_r);
  assign rate5 = {3'b000, rate_r} + {1'b0, rate_r, 2'b00};
  assign kgain = (rate5 > 17'd65536) ? 17'd65536 : rate5;

  always_comb begin
    case (cmd.sm_par)
      atsc_pkg::PAR_AMOUNT: begin
        sm_cur = ASYM_W'(cur_amount_r); sm_tgt = ASYM_W'(tgt_amount_r);
        sm_band = atsc_pkg::BAND_AMOUNT;
      end
      atsc_pkg::PAR_PRE: begin
        sm_cur = ASYM_W'(cur_pre_r); sm_tgt = ASYM_W'(tgt_pre_r);
        sm_band = atsc_pkg::BAND_GAIN;
      end
      atsc_pkg::PAR_POST: begin
        sm_cur = ASYM_W'(cur_post_r); sm_tgt = ASYM_W'(tgt_post_r);
        sm_band = atsc_pkg::BAND_GAIN;
      end
      default: begin
        sm_cur = cur_asym_r; sm_tgt = tgt_asym_r;
        sm_band = atsc_pkg::BAND_ASYM;
      end
    endcase
    sm_up   = sm_cur < sm_tgt;
    sm_diff = sm_up ? (sm_tgt - sm_cur) : (sm_cur - sm_tgt);
    sm_sum  = prod_r[32:0] + 33'd65535;
    sm_step = sm_sum[32:16];
    sm_add  = {1'b0, sm_cur} + {1'b0, sm_step};
    sm_sub  = {1'b0, sm_cur} - {1'b0, sm_step};
    if (sm_cur == sm_tgt || sm_diff < sm_band) sm_new = sm_cur;
    else if (sm_step >= sm_diff)                sm_new = sm_tgt;
    else if (sm_up)                             sm_new = sm_add[ASYM_W-1:0];
    else                                        sm_new = sm_sub[ASYM_W-1:0];
  end

  always_comb begin
    cur_amount_nxt = cur_amount_r;
    cur_pre_nxt    = cur_pre_r;
    cur_post_nxt   = cur_post_r;
    cur_asym_nxt   = cur_asym_r;
    if (cmd.load_in && in_snap_params) begin
      cur_amount_nxt = tgt_amount_r;
      cur_pre_nxt    = tgt_pre_r;
      cur_post_nxt   = tgt_post_r;
      cur_asym_nxt   = tgt_asym_r;
    end
    if (cmd.sm_upd) begin
      case (cmd.sm_par)
        atsc_pkg::PAR_AMOUNT: cur_amount_nxt = sm_new[AMT_W-1:0];
        atsc_pkg::PAR_PRE:    cur_pre_nxt    = sm_new[GAIN_W-1:0];
        atsc_pkg::PAR_POST:   cur_post_nxt   = sm_new[GAIN_W-1:0];
        default:              cur_asym_nxt   = sm_new;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_amount_r <= atsc_pkg::RST_AMOUNT;
      cur_pre_r    <= atsc_pkg::RST_PRE_GAIN;
      cur_post_r   <= atsc_pkg::RST_POST_GAIN;
      cur_asym_r   <= atsc_pkg::RST_ASYMMETRY;
    end else begin
      cur_amount_r <= cur_amount_nxt;
      cur_pre_r    <= cur_pre_nxt;
      cur_post_r   <= cur_post_nxt;
      cur_asym_r   <= cur_asym_nxt;
    end
  end

  assign stat.amount_zero = (cur_amount_r == '0);

  // ---------------- shared multiplier ----------------
  logic [SW-1:0]  s_mag;
  logic [CFW-1:0] cf;
  logic [OPW-1:0] mul_a, mul_b;

  assign s_mag = sample_r[SW-1] ? (~sample_r + 1'b1) : sample_r;
  assign cf    = {2'b00, cur_asym_r} + {1'b0, cur_asym_r, 1'b0} + CFW'(65536);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      atsc_pkg::MUL_SM_AMT:  begin mul_a = OPW'(damt);      mul_b = OPW'(rate_r);     end
      atsc_pkg::MUL_SM_PRE:  begin mul_a = OPW'(cur_pre_r); mul_b = OPW'(kgain);      end
      atsc_pkg::MUL_SM_POST: begin mul_a = OPW'(cur_post_r); mul_b = OPW'(kgain);     end
      atsc_pkg::MUL_SM_ASYM: begin mul_a = OPW'(dasym);     mul_b = OPW'(rate_r);     end
      atsc_pkg::MUL_DRIVE:   begin mul_a = OPW'(s_mag);     mul_b = OPW'(cur_pre_r);  end
      atsc_pkg::MUL_ARG: begin
        mul_a = OPW'(x_mag_r);
        mul_b = x_pos_r ? OPW'(65536) : OPW'(cf);
      end
      atsc_pkg::MUL_IDX: begin
        mul_a = OPW'(u_r[SPAN-1:0]); mul_b = OPW'(EXP_TABLE_DEPTH);
      end
      atsc_pkg::MUL_INTERP:  begin mul_a = OPW'(diff_r);    mul_b = OPW'(fr_r);       end
      atsc_pkg::MUL_POST:    begin mul_a = OPW'(y_mag_r);   mul_b = OPW'(cur_post_r); end
      atsc_pkg::MUL_MIX:     begin mul_a = OPW'(d_mag_r);   mul_b = OPW'(cur_amount_r); end
      atsc_pkg::MUL_RECIP:   begin mul_a = OPW'(t_r);       mul_b = OPW'(RECIP);      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
  end

  // ---------------- exp table ----------------
  logic [AW-1:0] rom_addr;
  logic [EW-1:0] rom_q;

  assign rom_addr = cmd.rom_hi ? (idx_r + 1'b1) : idx_r;

  atsc_exp_rom #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  // ---------------- per-sample stages ----------------
  logic [PW-1:0]        xs, us, ws, ts;
  logic [XW-1:0]        x_mag;
  logic                 u_big;
  logic [EW-1:0]        ip, e_val;
  logic [WMW-1:0]       w_mag;
  logic signed [WW-1:0] d_val;
  logic [QW-1:0]        q_val;
  logic signed [RW-1:0] s_ext, res;
  logic signed [RW-1:0] lim_hi, lim_lo;

  assign xs    = prod_r + PW'(2048);
  assign x_mag = xs[XW+11:12];
  assign us    = prod_r + PW'(32768);
  assign u_big = |u_r[UW-1:SPAN];
  assign ip    = prod_r[SPAN+EW-1:SPAN];
  assign e_val = u_big ? '0 : (down_r ? (lo_r - ip) : (lo_r + ip));
  assign ws    = prod_r + PW'(2048);
  assign w_mag = ws[WMW+11:12];
  assign d_val = w_r - WW'(sample_r);
  assign ts    = prod_r + PW'(12800);
  assign q_val = prod_r[QS+QW-1:QS];
  assign s_ext = RW'(sample_r);
  assign res   = d_neg_r ? (s_ext - $signed({1'b0, q_val}))
                         : (s_ext + $signed({1'b0, q_val}));
  assign lim_hi = RW'({1'b0, {(SW-1){1'b1}}});
  assign lim_lo = -(RW'(1) <<< (SW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) sample_r <= in_sample_in;
    if (cmd.lat_x) begin
      x_mag_r <= x_mag;
      x_pos_r <= !sample_r[SW-1] && (x_mag != '0);
    end
    if (cmd.lat_u) u_r <= us[UW+15:16];
    if (cmd.lat_idx) begin
      idx_r <= prod_r[SPAN+AW-1:SPAN];
      fr_r  <= prod_r[SPAN-1:0];
    end
    if (cmd.lat_lo) lo_r <= rom_q;
    if (cmd.lat_diff) begin
      down_r <= (lo_r >= rom_q);
      diff_r <= (lo_r >= rom_q) ? (lo_r - rom_q) : (rom_q - lo_r);
    end
    if (cmd.lat_y) begin
      y_mag_r <= (EW'(1) << F) - e_val;
      y_neg_r <= !x_pos_r;
    end
    if (cmd.lat_w) w_r <= y_neg_r ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    if (cmd.lat_d) begin
      d_neg_r <= d_val[WW-1];
      d_mag_r <= d_val[WW-1] ? DMW'(-d_val) : DMW'(d_val);
    end
    if (cmd.lat_t) t_r <= ts[TW+9:10];
    if (cmd.load_out) begin
      out_bypassed_r <= cmd.bypass;
      if (cmd.bypass)         out_sample_r <= sample_r;
      else if (res > lim_hi)  out_sample_r <= lim_hi[SW-1:0];
      else if (res < lim_lo)  out_sample_r <= lim_lo[SW-1:0];
      else                    out_sample_r <= res[SW-1:0];
    end
  end

  assign out_sample_out = out_sample_r;
  assign out_bypassed   = out_bypassed_r;

endmodule
`default_nettype wire

### hw/rtl/asymmetric_tube_soft_clipper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asymmetric_tube_soft_clipper_core
// Sequencing: the controller accepts a new sample only while idle, after the
//   previous one has gone through its sequence; a smoothing tick adds a pass,
//   and a bypassed sample leaves the sequence after the drive product. Every
//   product goes through the single shared multiplier.
// Reset: synchronous active-low rst_n restores all targets and current
//   parameters to their defaults and empties the result register.
// ----------------------------------------------------------------------------
module asymmetric_tube_soft_clipper_core #(
  parameter int SAMPLE_WIDTH    = atsc_pkg::SAMPLE_WIDTH,
  parameter int EXP_TABLE_DEPTH = atsc_pkg::EXP_TABLE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [atsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [atsc_pkg::CFG_W-1:0]      cfg_data,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  input  wire logic                            in_smooth_tick,
  input  wire logic                            in_snap_params,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_sample_out,
  output logic                                 out_bypassed
);

  // The controller steps each sample through the datapath. A sample is taken
  // only while the controller is idle, but the result register lets a new
  // transfer start while the previous result is still waiting downstream.
  // Snap is applied at the input transfer; the optional smoothing pass then
  // moves each current parameter one step before the shaping starts.
  atsc_pkg::dp_cmd_t  cmd;
  atsc_pkg::dp_stat_t stat;

  atsc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_smooth_tick (in_smooth_tick),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .stat           (stat)
  );

  // The datapath holds the registers, the shared multiplier, the exp table
  // (two registered reads per non-bypassed sample for interpolation) and the result.
  atsc_dp #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .in_snap_params (in_snap_params),
    .cmd            (cmd),
    .stat           (stat),
    .out_sample_out (out_sample_out),
    .out_bypassed   (out_bypassed)
  );

endmodule
`default_nettype wire
